/* hdl/window_level_meter_macros.svh */
// Assertion macros for the window level meter checker.
// Depends on nothing; included by the checker file.
`ifndef WINDOW_LEVEL_METER_MACROS_SVH
`define WINDOW_LEVEL_METER_MACROS_SVH

// same-cycle implication, disabled during reset
`define WLM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window_level_meter assertion failed");

// next-cycle implication, disabled during reset
`define WLM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("window_level_meter assertion failed");

`endif

/* hdl/wlm_pkg.sv */
// Shared constants, state type and command struct of the window level meter.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package wlm_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int LEVEL_W    = 24;
   localparam int MAX_WINDOW = 65536;
   localparam int COUNT_W    = 17;
   localparam int MSUM_W     = 40;
   localparam int SSUM_W     = 63;
   localparam int DIV_W      = SSUM_W;
   localparam int STEP_W     = 6;
   localparam int ROOT_IN_W  = 64;
   localparam int ROOT_W     = 32;
   localparam int ROOT_REM_W = 34;
   localparam int ROOT_STEPS = 32;

   localparam logic [LEVEL_W-1:0] LIMIT_RESET = 24'd4198498;
   localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(DIV_W);
   localparam logic [STEP_W-1:0]  ROOT_LAST   = STEP_W'(ROOT_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_MEAN,
      ST_SQUARE,
      ST_ROOT,
      ST_PUBLISH
   } wlm_state_type;

   typedef struct packed {
      logic capture;
      logic mean_load;
      logic square_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic publish;
   } wlm_cmd_type;

endpackage
`default_nettype wire

/* hdl/wlm_ctrl.sv */
// Controller of the window level meter: sequencing of capture, divides, root and result.
// Depends on wlm_pkg; drives wlm_dp through the command struct.
`default_nettype none
module wlm_ctrl
   import wlm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output wlm_cmd_type      cmd
);

   wlm_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_MEAN;
            step_in  = '0;
         end
         ST_MEAN: begin
            cmd.mean_load = (step_ff == '0);
            cmd.div_step  = (step_ff != '0);
            step_in       = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SQUARE;
               step_in  = '0;
            end
         end
         ST_SQUARE: begin
            cmd.square_load = (step_ff == '0);
            cmd.div_step    = (step_ff != '0);
            step_in         = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_ROOT;
               step_in  = '0;
            end
         end
         ST_ROOT: begin
            cmd.root_load = (step_ff == '0);
            cmd.root_step = (step_ff != '0);
            step_in       = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               state_in = ST_PUBLISH;
               step_in  = '0;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* hdl/wlm_dp.sv */
// Datapath of the window level meter: limit register, accumulators, shared
// restoring divider, digit-by-digit square root and result register. Depends on wlm_pkg.
`default_nettype none
module wlm_dp
   import wlm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire wlm_cmd_type                cmd,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       csr_valid,
   input  wire logic [LEVEL_W-1:0]         csr_reject_limit,
   output logic [LEVEL_W-1:0]              rsp_mean_abs,
   output logic [LEVEL_W-1:0]              rsp_rms,
   output logic [LEVEL_W-1:0]              rsp_peak,
   output logic                            rsp_none_accepted
);

   logic [LEVEL_W-1:0]     limit_ff;
   logic [LEVEL_W-1:0]     mag;
   logic                   count_open;
   logic                   take_ff, take_in;
   logic [LEVEL_W-1:0]     mag_ff;
   logic [MSUM_W-1:0]      msum_ff;
   logic [SSUM_W-1:0]      ssum_ff;
   logic [2*LEVEL_W-1:0]   square;
   logic [LEVEL_W-1:0]     peak_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   any_ff;

   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [COUNT_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W:0]       div_trial;
   logic                   div_ge;
   logic [LEVEL_W-1:0]     mean_ff;

   logic [ROOT_IN_W-1:0]   src_ff, src_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [ROOT_REM_W-1:0]  rrem_ff, rrem_in;
   logic [ROOT_REM_W+1:0]  rshift, rtrial;
   logic                   root_ge;

   logic [LEVEL_W-1:0]     out_mean_ff, out_rms_ff, out_peak_ff;
   logic                   out_none_ff;

   assign mag        = req_sample[SAMPLE_W-1] ? LEVEL_W'(~req_sample + 1'b1)
                                              : LEVEL_W'(req_sample);
   assign count_open = (count_ff < COUNT_W'(MAX_WINDOW));
   assign take_in    = cmd.capture && count_open && (mag <= limit_ff);
   assign square     = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         take_ff  <= 1'b0;
         msum_ff  <= '0;
         ssum_ff  <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
         any_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_reject_limit;
         end
         take_ff <= take_in;
         if (cmd.publish) begin
            msum_ff  <= '0;
            ssum_ff  <= '0;
            peak_ff  <= '0;
            count_ff <= '0;
            any_ff   <= 1'b0;
         end else begin
            if (cmd.capture && count_open) begin
               count_ff <= count_ff + 1'b1;
            end
            if (take_ff) begin
               msum_ff <= msum_ff + MSUM_W'(mag_ff);
               ssum_ff <= ssum_ff + SSUM_W'(square);
               any_ff  <= 1'b1;
               if (mag_ff > peak_ff) begin
                  peak_ff <= mag_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff <= mag;
      end
   end

   // one quotient bit per step
   assign div_trial = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, count_ff});

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.mean_load) begin
         quo_in = DIV_W'(msum_ff);
         rem_in = '0;
      end else if (cmd.square_load) begin
         quo_in = ssum_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[DIV_W-2:0], div_ge};
         rem_in = div_ge ? COUNT_W'(div_trial - {1'b0, count_ff}) : COUNT_W'(div_trial);
      end
   end

   // two radicand bits per step
   assign rshift  = {rrem_ff, src_ff[ROOT_IN_W-1 -: 2]};
   assign rtrial  = {2'b00, root_ff, 2'b01};
   assign root_ge = (rshift >= rtrial);

   always_comb begin
      src_in  = src_ff;
      root_in = root_ff;
      rrem_in = rrem_ff;
      if (cmd.root_load) begin
         src_in  = ROOT_IN_W'(quo_ff);
         root_in = '0;
         rrem_in = '0;
      end else if (cmd.root_step) begin
         src_in  = {src_ff[ROOT_IN_W-3:0], 2'b00};
         root_in = {root_ff[ROOT_W-2:0], root_ge};
         rrem_in = root_ge ? ROOT_REM_W'(rshift - rtrial) : ROOT_REM_W'(rshift);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      if (cmd.square_load) begin
         mean_ff <= quo_ff[LEVEL_W-1:0];
      end
      if (cmd.publish) begin
         out_mean_ff <= mean_ff;
         out_rms_ff  <= root_ff[LEVEL_W-1:0];
         out_peak_ff <= peak_ff;
         out_none_ff <= ~any_ff;
      end
   end

   assign rsp_mean_abs      = out_mean_ff;
   assign rsp_rms           = out_rms_ff;
   assign rsp_peak          = out_peak_ff;
   assign rsp_none_accepted = out_none_ff;

endmodule
`default_nettype wire

/* hdl/window_level_meter.sv */
// Top level of the window level meter: joins controller and datapath.
// Depends on wlm_pkg, wlm_ctrl and wlm_dp.
//
//   channel  prefix  word carries
//   input    req_    sample, last
//   result   rsp_    mean_abs, rms, peak, none_accepted
//   config   csr_    reject_limit (always ready)
//
// Samples that are not the last of their window may follow back to back. A last sample
// closes the window: req_ready stays low until the result is published, while the
// shared restoring divider runs for the mean and then for the mean square, and the
// root unit runs at two bits a step.
// The result register holds the word until taken; a new window may start meanwhile,
// and the next result waits only if the previous one is still untaken.
// Reset clears all window state and loads the default reject limit.
`default_nettype none
module window_level_meter
   import wlm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [LEVEL_W-1:0]              rsp_mean_abs,
   output logic [LEVEL_W-1:0]              rsp_rms,
   output logic [LEVEL_W-1:0]              rsp_peak,
   output logic                            rsp_none_accepted,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [LEVEL_W-1:0]         csr_reject_limit
);

   wlm_cmd_type cmd;

   assign csr_ready = 1'b1;

   wlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   wlm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_sample        (req_sample),
      .csr_valid         (csr_valid),
      .csr_reject_limit  (csr_reject_limit),
      .rsp_mean_abs      (rsp_mean_abs),
      .rsp_rms           (rsp_rms),
      .rsp_peak          (rsp_peak),
      .rsp_none_accepted (rsp_none_accepted)
   );

endmodule
`default_nettype wire

/* hdl/wlm_checker.sv */
// Port-level checks of the window level meter, bound to the top level.
// Depends on wlm_pkg and window_level_meter_macros.svh.
`default_nettype none
`include "window_level_meter_macros.svh"
module wlm_checker
   import wlm_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_last,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [LEVEL_W-1:0]         rsp_mean_abs,
   input wire logic [LEVEL_W-1:0]         rsp_rms,
   input wire logic [LEVEL_W-1:0]         rsp_peak,
   input wire logic                       rsp_none_accepted
);

   logic [LEVEL_W-1:0] full_scale;
   logic               last_take;
   logic               all_zero;
   logic               in_order;

   assign full_scale = LEVEL_W'(1) << (SAMPLE_W - 1);
   assign last_take  = req_valid && req_ready && req_last;
   assign all_zero   = (rsp_peak == '0) && (rsp_mean_abs == '0) && (rsp_rms == '0);
   assign in_order   = (rsp_mean_abs <= rsp_peak) && (rsp_rms <= rsp_peak)
                       && (rsp_peak <= full_scale);

   `WLM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `WLM_ASSERT_NXT(a_last_stalls, clock, reset, last_take, !req_ready)

   `WLM_ASSERT_IMP(a_none_zero, clock, reset, rsp_valid && rsp_none_accepted, all_zero)

   `WLM_ASSERT_IMP(a_level_order, clock, reset, rsp_valid, in_order)

endmodule

bind window_level_meter wlm_checker u_wlm_checker (.*);
`default_nettype wire
